// ===== hw/rtl/iqlr_pkg.sv =====
// shared constants and types for the i/q linear interpolation resampler
`default_nettype none

package iqlr_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int FRAC_W     = 11;
  localparam int PHASE_W    = 14;
  localparam int STEP_W     = 13;
  localparam int OUT_PER_MS = 2048;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IQ_SWAP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IN_PER_MS = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0] IN_PER_MS_RST = STEP_W'(3072);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [FRAC_W-1:0]          frac_t;
  typedef logic [STEP_W-1:0]          step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iqlr_if.sv =====
// channel interfaces: input samples, interpolated results, register writes
`default_nettype none

interface iqlr_in_if import iqlr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_i;
  sample_t in_q;

  modport source (output valid, output in_i, output in_q, input ready);
  modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

interface iqlr_out_if import iqlr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_i;
  sample_t out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

interface iqlr_cfg_if import iqlr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iqlr_blend.sv =====
// floored linear blend of two samples: prev + floor((cur - prev) * frac / 2048)
`default_nettype none

module iqlr_blend import iqlr_pkg::*; (
  input  sample_t prev,
  input  sample_t cur,
  input  frac_t   frac,
  output sample_t blend
);

  logic signed [SAMPLE_W:0]                diff_s;
  logic signed [SAMPLE_W+FRAC_W+1:0]       prod_s;
  logic        [SAMPLE_W+1:0]              sum;

  assign diff_s = $signed({cur[SAMPLE_W-1], cur}) - $signed({prev[SAMPLE_W-1], prev});
  assign prod_s = diff_s * $signed({1'b0, frac});

  // arithmetic drop of the fraction bits gives the floor
  assign sum   = {{2{prev[SAMPLE_W-1]}}, prev} + prod_s[SAMPLE_W+FRAC_W+1:FRAC_W];
  assign blend = sample_t'(sum[SAMPLE_W-1:0]);

endmodule

`default_nettype wire

// ===== hw/rtl/iq_linear_interp_resampler_unit.sv =====
// top level: linear interpolation fractional resampler for complex i/q samples
// a result is registered and becomes valid in the cycle after the transaction of the sample that causes it
// throughput: one sample per cycle while no result is stalled; at most one result per sample, set by the phase step
// the first sample after reset only primes the previous-sample register and gives no result
// rst_n (synchronous) clears phase, history and output valid and restores register defaults
`default_nettype none

module iq_linear_interp_resampler_unit import iqlr_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  iqlr_in_if.sink     in_ch,
  iqlr_out_if.source  out_ch,
  iqlr_cfg_if.sink    cfg_ch
);

  logic    iq_swap_r;
  step_t   in_per_ms_r;
  sample_t prev_i_r, prev_q_r;
  phase_t  phase_r, phase_nxt;
  logic    have_prev_r;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_i_r, out_q_r;

  logic    in_fire, cfg_fire, due;
  sample_t cur_i, cur_q, blend_i, blend_q;
  step_t   step;
  phase_t  phase_base;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;

  assign cur_i = iq_swap_r ? in_ch.in_q : in_ch.in_i;
  assign cur_q = iq_swap_r ? in_ch.in_i : in_ch.in_q;

  // steps below one input sample are clamped to one
  assign step = (in_per_ms_r < STEP_W'(OUT_PER_MS)) ? STEP_W'(OUT_PER_MS) : in_per_ms_r;

  // output due while the next position still lies before the current sample
  assign due        = (phase_r < PHASE_W'(OUT_PER_MS));
  assign phase_base = due ? phase_r + PHASE_W'(step) : phase_r;
  assign phase_nxt  = have_prev_r ? phase_base - PHASE_W'(OUT_PER_MS) : '0;

  iqlr_blend u_blend_i (
    .prev  (prev_i_r),
    .cur   (cur_i),
    .frac  (phase_r[FRAC_W-1:0]),
    .blend (blend_i)
  );

  iqlr_blend u_blend_q (
    .prev  (prev_q_r),
    .cur   (cur_q),
    .frac  (phase_r[FRAC_W-1:0]),
    .blend (blend_q)
  );

  always_comb begin
    priority if (in_fire && have_prev_r && due) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_swap_r   <= 1'b0;
      in_per_ms_r <= IN_PER_MS_RST;
      phase_r     <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      prev_i_r    <= '0;
      prev_q_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        if (cfg_ch.index == CFG_IQ_SWAP) begin
          iq_swap_r <= cfg_ch.data[0];
        end
        if (cfg_ch.index == CFG_IN_PER_MS) begin
          in_per_ms_r <= cfg_ch.data[STEP_W-1:0];
        end
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        have_prev_r <= 1'b1;
        prev_i_r    <= cur_i;
        prev_q_r    <= cur_q;
      end
    end
  end

  // result payload, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (in_fire && have_prev_r && due) begin
      out_i_r <= blend_i;
      out_q_r <= blend_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iqlr_checker.sv =====
// port-level assertions for the resampler top level, with the bind that attaches them
`default_nettype none

module iqlr_checker import iqlr_pkg::*; (
  input wire     clk,
  input wire     rst_n,
  input wire     in_valid,
  input wire     in_ready,
  input wire     out_valid,
  input wire     out_ready,
  input sample_t out_i,
  input sample_t out_q,
  input wire     cfg_ready
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_i) && $stable(out_q))
    else $error("result changed while stalled");

  // the input side only waits on a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input not ready although output free");

  // every new result follows an input transaction
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transaction");

  // register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind iq_linear_interp_resampler_unit iqlr_checker u_iqlr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_i     (out_ch.out_i),
  .out_q     (out_ch.out_q),
  .cfg_ready (cfg_ch.ready)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the i/q linear interpolation resampler: drives samples, predicts and checks results
`timescale 1ns / 1ps

import iqlr_pkg::*;

typedef struct packed {
  sample_t i;
  sample_t q;
} iq_pair_t;

class resampler_scoreboard;
  bit       swap_en;
  step_t    step_reg;
  sample_t  prev_i;
  sample_t  prev_q;
  phase_t   phase;
  bit       primed;
  iq_pair_t interp_q[$];
  int       errors;

  function new();
    swap_en  = 1'b0;
    step_reg = IN_PER_MS_RST;
    prev_i   = '0;
    prev_q   = '0;
    phase    = '0;
    primed   = 1'b0;
    errors   = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IQ_SWAP: begin
        swap_en = data[0];
      end
      CFG_IN_PER_MS: begin
        step_reg = step_t'(data);
      end
      default: begin
      end
    endcase
  endfunction

  // floored weighted mean, weight f/2048 on b
  function sample_t blend(sample_t a, sample_t b, frac_t f);
    longint acc;
    acc = longint'(a) * longint'(OUT_PER_MS - int'(f)) + longint'(b) * longint'(int'(f));
    return sample_t'(acc >>> FRAC_W);
  endfunction

  function void note_sample(sample_t a, sample_t b);
    sample_t  ci;
    sample_t  cq;
    int       eff_step;
    iq_pair_t interp;
    ci = swap_en ? b : a;
    cq = swap_en ? a : b;
    eff_step = (int'(step_reg) < OUT_PER_MS) ? OUT_PER_MS : int'(step_reg);
    if (!primed) begin
      prev_i = ci;
      prev_q = cq;
      phase  = '0;
      primed = 1'b1;
      return;
    end
    if (int'(phase) < OUT_PER_MS) begin
      interp.i = blend(prev_i, ci, frac_t'(phase));
      interp.q = blend(prev_q, cq, frac_t'(phase));
      interp_q.push_back(interp);
      phase = phase + phase_t'(eff_step);
    end
    phase  = phase - phase_t'(OUT_PER_MS);
    prev_i = ci;
    prev_q = cq;
  endfunction

  function void check_result(sample_t got_i, sample_t got_q);
    iq_pair_t interp;
    if (interp_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: i=%0d q=%0d", got_i, got_q);
      return;
    end
    interp = interp_q.pop_front();
    if (got_i !== interp.i || got_q !== interp.q) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                 interp.i, interp.q, got_i, got_q);
    end
  endfunction

  function int pending();
    return interp_q.size();
  endfunction

  function int failures();
    return errors + interp_q.size();
  endfunction
endclass

module tb_top;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
  localparam sample_t S_MAX = 32'sh7FFF_FFFF;
  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n;

  iqlr_in_if  in_ch ();
  iqlr_out_if out_ch ();
  iqlr_cfg_if cfg_ch ();

  iq_linear_interp_resampler_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  resampler_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // results are checked before the sample of the same edge is noted
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_i, out_ch.out_q);
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.in_i, in_ch.in_q);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic sample_t rand_word();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] step_for(int k);
    case (k)
      0: return CFG_DATA_W'(2048);
      1: return CFG_DATA_W'(8191);
      2: return CFG_DATA_W'(2047);
      3: return CFG_DATA_W'($urandom_range(2049, 8190));
      4: return CFG_DATA_W'(4096);
      5: return CFG_DATA_W'(0);
      6: return CFG_DATA_W'($urandom_range(0, 8191));
      7: return CFG_DATA_W'(3072);
      default: return CFG_DATA_W'($urandom_range(2048, 8191));
    endcase
  endfunction

  // leaves valid high; wait_drained or an idle draw of the next sample drops it
  task automatic send_sample(input sample_t a, input sample_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_i  <= a;
    in_ch.in_q  <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
  endtask

  // drops valid and lets the monitor note the last sample before waiting on the scoreboard
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] swap_word,
                           input logic [CFG_DATA_W-1:0] step_word);
    wait_drained();
    cfg_write(CFG_IQ_SWAP, swap_word);
    cfg_write(CFG_IN_PER_MS, step_word);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_i    = '0;
    in_ch.in_q    = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // indexes past the register list must change nothing
    cfg_write(CFG_SPARE_2, '1);
    cfg_write(CFG_SPARE_3, '1);
    cfg_ch.valid <= 1'b0;

    // default step; first sample only primes the history
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(32'sd0, -32'sd1);
    send_sample(-32'sd1, 32'sd0);
    send_sample(32'sd1, -32'sd2);
    send_sample(32'sh5555_5555, 32'shAAAA_AAAA);
    send_sample(32'shAAAA_AAAA, 32'sh5555_5555);

    // step below range acts as one output per input, swap changes mid-stream
    configure(CFG_DATA_W'(1), CFG_DATA_W'(0));
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(32'sd7, -32'sd7);
    send_sample(S_MAX, S_MAX);
    send_sample(-32'sd1, 32'sd1);

    // largest step, swap bit 0 clear with upper bits set
    configure(CFG_DATA_W'(13'h1FFE), CFG_DATA_W'(8191));
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(32'sd0, 32'sd0);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(32'sd3, -32'sd3);
    send_sample(-32'sd1, -32'sd1);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        configure({12'($urandom), 1'((ph * 3 + seg) % 2)}, step_for(ph * 3 + seg));
        for (int n = 0; n < 50; n++)
          send_sample(rand_word(), rand_word());
      end
    end

    wait_drained();
    if (sb.failures() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/iqlr_pkg.sv
hw/rtl/iqlr_if.sv
hw/rtl/iqlr_blend.sv
hw/rtl/iq_linear_interp_resampler_unit.sv
hw/rtl/iqlr_checker.sv
tb/tb_top.sv
